>>> sv/life_generation_stencil_unit_assert.svh
// assertion helpers for the life generation stencil unit
// both expect signals named clk and rst in the module that uses them
`ifndef LIFE_GENERATION_STENCIL_UNIT_ASSERT_SVH
`define LIFE_GENERATION_STENCIL_UNIT_ASSERT_SVH

// condition holds at every edge outside reset
`define LGS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define LGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lgs_pkg.sv
package lgs_pkg;

  // register map
  localparam int REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int WIDTH_W  = 10;  // frame_width register
  localparam int HEIGHT_W = 12;  // frame_height register
  localparam int CFG_DATA_W = 12;
  localparam int ROW_W    = 13;  // row counter runs to height + 1

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd400;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd300;

  localparam int LGS_MAX_WIDTH = 512;
  localparam int LGS_MIN_DIM   = 3;

  // B3/S23
  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  // which window borders lie inside the frame
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_mask_t;

endpackage

>>> sv/lgs_row_store.sv
module lgs_row_store #(
  parameter int DEPTH  = lgs_pkg::LGS_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [1:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [1:0]        rd_data
);
  import lgs_pkg::*;

  // bit 1: row two above, bit 0: row just above
  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, forwarding a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/lgs_rule.sv
module lgs_rule (
  input  logic               [8:0] window,
  input  lgs_pkg::edge_mask_t      edges,
  output logic                     next_alive
);
  import lgs_pkg::*;

  logic [3:0] cnt;

  // window bits: col*3 + row, col 0 left, row 0 top, centre is bit 4
  always_comb begin
    cnt = 4'd0;
    cnt = cnt + {3'b0, window[0] & edges.left & edges.top};
    cnt = cnt + {3'b0, window[1] & edges.left};
    cnt = cnt + {3'b0, window[2] & edges.left & edges.bottom};
    cnt = cnt + {3'b0, window[3] & edges.top};
    cnt = cnt + {3'b0, window[5] & edges.bottom};
    cnt = cnt + {3'b0, window[6] & edges.right & edges.top};
    cnt = cnt + {3'b0, window[7] & edges.right};
    cnt = cnt + {3'b0, window[8] & edges.right & edges.bottom};
  end

  assign next_alive = window[4] ? ((cnt == SURVIVE_LO) || (cnt == BIRTH_CNT))
                                : (cnt == BIRTH_CNT);

endmodule

>>> sv/life_generation_stencil_unit.sv
// Streaming Game of Life stepper, rule B3/S23. Cells of one generation enter in
// raster order, one per transfer; the next generation leaves in the same order,
// one row and one column behind the input. The unit takes one cell per clock:
// a result is registered at the transfer that completes its 3x3 neighborhood,
// and in_stall rises only while a finished result is held by
// out_stall. After the last cell of a frame, send frame_width + 1 drain items to
// flush the final row; the result flagged end_of_frame returns the unit to the
// start of a new frame. A drain item at the start of a frame is taken and
// dropped. Cells outside the frame count as dead. frame_width is clamped to
// [3, MAX_WIDTH], frame_height to at least 3. A register write restarts the
// frame position; write only while idle. The two line stores share one
// memory of MAX_WIDTH two-bit entries with a registered read that is fetched
// one cell ahead; they need no clearing after reset.
`include "life_generation_stencil_unit_assert.svh"

module life_generation_stencil_unit #(
  parameter int MAX_WIDTH = lgs_pkg::LGS_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [lgs_pkg::REG_INDEX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input cells
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cell_alive,
  input  logic                             drain,
  // next generation
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             next_alive,
  output logic                             end_of_frame
);
  import lgs_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  // widest usable row, limited by the register width
  localparam logic [WIDTH_W-1:0] WIDTH_CAP =
    (MAX_WIDTH > ((1 << WIDTH_W) - 1)) ? {WIDTH_W{1'b1}} : WIDTH_W'(MAX_WIDTH);

  // configuration registers
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  // frame position of the next input cell
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] row_next;

  // 3x3 window, one column per cell
  logic [8:0] window;
  logic [8:0] window_next;

  // line store read, prefetched one cell ahead
  logic [1:0]       store_rd;
  logic [COL_W-1:0] rd_addr;

  logic       in_xfer;
  logic       skip;       // drain with nothing in flight
  logic       step;       // transfer that moves the stencil
  logic       cell_bit;
  logic       emit;
  logic       last;
  logic       emit_mid;   // result for a cell left of the current column
  logic       emit_wrap;  // result for the last cell of the row two above
  logic       rule_out;
  logic [ROW_W-1:0] h_ext;
  logic [ROW_W-1:0] col_inc;
  logic [ROW_W-1:0] w_ext;
  edge_mask_t edges;

  // effective frame size
  always_comb begin
    w_eff = frame_width;
    if (frame_width > WIDTH_CAP) begin
      w_eff = WIDTH_CAP;
    end else if (frame_width < WIDTH_W'(LGS_MIN_DIM)) begin
      w_eff = WIDTH_W'(LGS_MIN_DIM);
    end
    h_eff = (frame_height < HEIGHT_W'(LGS_MIN_DIM)) ? HEIGHT_W'(LGS_MIN_DIM) : frame_height;
  end

  assign h_ext = ROW_W'(h_eff);
  assign w_ext = ROW_W'(w_eff);

  // handshake: hold input only while a finished result is held downstream
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign skip     = drain && (col == '0) && (row == '0);
  assign step     = in_xfer & ~skip;

  // past the last row every item, and any drain item, counts as padding
  assign cell_bit = ((row >= h_ext) || drain) ? 1'b0 : cell_alive;

  // new right column: top from two rows up, middle from one row up, bottom is input
  assign window_next = {cell_bit, store_rd[0], store_rd[1], window[8:3]};

  // which output cell, if any, the shifted window centers on
  assign emit_mid  = (col != '0) && (row != '0) && (row <= h_ext);
  assign emit_wrap = (col == '0) && (row >= ROW_W'(2));
  assign emit      = emit_mid | emit_wrap;
  assign last      = emit_wrap && (row >= h_ext + ROW_W'(1));

  always_comb begin
    if (emit_wrap) begin
      // rightmost column: no right neighbors
      edges.left   = 1'b1;
      edges.right  = 1'b0;
      edges.top    = (row >= ROW_W'(3));
      edges.bottom = (row <= h_ext);
    end else begin
      edges.left   = (col >= COL_W'(2));
      edges.right  = 1'b1;
      edges.top    = (row >= ROW_W'(2));
      edges.bottom = (row < h_ext);
    end
  end

  lgs_rule u_rule (
    .window     (window_next),
    .edges      (edges),
    .next_alive (rule_out)
  );

  // raster position advance
  assign col_inc = ROW_W'(col) + ROW_W'(1);
  always_comb begin
    col_next = col;
    row_next = row;
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_ext) begin
      col_next = '0;
      row_next = row + ROW_W'(1);
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
  end

  // fetch the entry the next cell will use; only a real register write restarts
  always_comb begin
    if (cfg_write && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT})) begin
      rd_addr = '0;
    end else if (step) begin
      rd_addr = col_next;
    end else begin
      rd_addr = col;
    end
  end

  lgs_row_store #(
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (step),
    .wr_addr (col),
    .wr_data ({store_rd[0], cell_bit}),
    .rd_addr (rd_addr),
    .rd_data (store_rd)
  );

  // writes to the two frame registers restart the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      window       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[WIDTH_W-1:0];
          col         <= '0;
          row         <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[HEIGHT_W-1:0];
          col          <= '0;
          row          <= '0;
        end
        default: begin
        end
      endcase
    end else if (step) begin
      col    <= col_next;
      row    <= row_next;
      window <= window_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= step & emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      next_alive   <= rule_out;
      end_of_frame <= last;
    end
  end

  `LGS_ASSERT_ALWAYS(a_col_in_row, ROW_W'(col) < w_ext, "column count reached the row width")
  `LGS_ASSERT_ALWAYS(a_row_bound, row <= h_ext + ROW_W'(1), "row count ran past the flush row")
  `LGS_ASSERT_NEXT(a_eof_restart, step && last, (col == '0) && (row == '0) && out_valid && end_of_frame, "end of frame did not restart the position")
  `LGS_ASSERT_NEXT(a_idle_drain, in_xfer && skip, !out_valid, "idle drain produced a result")

endmodule
